// ----- src/npws_pkg.sv -----
// ----------------------------------------------------------------------------
// npws_pkg
// Shared constants, types and helpers of the nearest point window search.
// ----------------------------------------------------------------------------
package npws_pkg;

   // table geometry and coordinate format
   localparam int MAX_POINTS  = 4096;
   localparam int COORD_BITS  = 24;
   localparam int ADDR_W      = $clog2(MAX_POINTS);
   localparam int CNT_W       = $clog2(MAX_POINTS + 1);

   // fixed field widths of the ports
   localparam int CMD_W       = 2;
   localparam int IDX_W       = 12;
   localparam int COUNT_W     = 13;
   localparam int POS_W       = 24;

   // distance arithmetic
   localparam int SQ_W        = 2 * COORD_BITS;
   localparam int DIST_W      = SQ_W + 2;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE  = 2'd0,
      CMD_FULL   = 2'd1,
      CMD_WINDOW = 2'd2,
      CMD_NONE   = 2'd3
   } npws_cmd_code_type;

   // one queued item: a table write or a scan
   typedef struct packed {
      logic                  is_write;
      logic [ADDR_W-1:0]     index;
      logic [CNT_W-1:0]      count;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
   } npws_entry_type;

   // number of entries in use, saturated to the table size
   function automatic logic [CNT_W-1:0] npws_eff_count(input logic [COUNT_W-1:0] cnt);
      logic [CNT_W-1:0] result;
      if (COUNT_W'(cnt) > COUNT_W'(MAX_POINTS)) begin
         result = CNT_W'(MAX_POINTS);
      end else begin
         result = CNT_W'(cnt);
      end
      return result;
   endfunction

endpackage

// ----- src/npws_ram.sv -----
// ----------------------------------------------------------------------------
// npws_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module npws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/npws_front.sv -----
// ----------------------------------------------------------------------------
// npws_front
// Accepts items, classifies them and works out the scan start and length.
// ----------------------------------------------------------------------------
module npws_front
   import npws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COUNT_W-1:0]    point_count,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [IDX_W-1:0]      req_entry_index,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic [IDX_W-1:0]      req_last_index,
   input  logic [COUNT_W-1:0]    req_window_size,
   output logic                  push_valid,
   input  logic                  queue_full,
   output npws_entry_type        push_entry
);

   localparam int BIT_CNT_W = $clog2(IDX_W + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MOD,
      S_WRAP,
      S_PUSH
   } state_type;

   state_type             state_ff,   state_in;
   npws_entry_type        entry_ff,   entry_in;
   logic [CNT_W-1:0]      rem_ff,     rem_in;
   logic [IDX_W-1:0]      shift_ff,   shift_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]      back_ff,    back_in;

   logic [CNT_W-1:0]      n;
   logic [CNT_W-1:0]      win;
   logic [CNT_W-1:0]      win_back;
   logic [CNT_W+1:0]      win3;
   logic [CNT_W-1:0]      win_fwd;
   logic [CNT_W-1:0]      rem_step;
   logic [CNT_W:0]        start_sum;
   logic                  accept;

   assign n         = npws_eff_count(point_count);
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // window span clamped to the count, split a quarter back, three quarters ahead
   assign win      = (CNT_W'(req_window_size) > n) ? n : CNT_W'(req_window_size);
   assign win_back = win >> 2;
   assign win3     = {2'b00, win} + {1'b0, win, 1'b0};
   assign win_fwd  = CNT_W'(win3 >> 2);

   // one restoring step of last_index modulo n
   always_comb begin
      rem_step = {rem_ff[CNT_W-2:0], shift_ff[IDX_W-1]};
      if (rem_step >= n) begin
         rem_step = rem_step - n;
      end
   end

   // first index of the window, wrapped once
   always_comb begin
      start_sum = {1'b0, rem_ff} + {1'b0, n} - {1'b0, back_ff};
      if (start_sum >= {1'b0, n}) begin
         start_sum = start_sum - {1'b0, n};
      end
   end

   // next state and registered outputs
   always_comb begin
      state_in   = state_ff;
      entry_in   = entry_ff;
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      bit_cnt_in = bit_cnt_ff;
      back_in    = back_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               entry_in.x = COORD_BITS'(req_pos_x);
               entry_in.y = COORD_BITS'(req_pos_y);
               entry_in.z = COORD_BITS'(req_pos_z);
               case (npws_cmd_code_type'(req_command))
                  CMD_WRITE: begin
                     entry_in.is_write = 1'b1;
                     entry_in.index    = ADDR_W'(req_entry_index);
                     entry_in.count    = '0;
                     if ({1'b0, req_entry_index} < (IDX_W + 1)'(MAX_POINTS)) begin
                        state_in = S_PUSH;
                     end
                  end
                  CMD_FULL: begin
                     entry_in.is_write = 1'b0;
                     entry_in.index    = '0;
                     entry_in.count    = n;
                     state_in          = S_PUSH;
                  end
                  CMD_WINDOW: begin
                     entry_in.is_write = 1'b0;
                     entry_in.index    = '0;
                     entry_in.count    = (n == '0) ? '0 : (win_back + win_fwd);
                     back_in           = win_back;
                     rem_in            = '0;
                     shift_in          = req_last_index;
                     bit_cnt_in        = BIT_CNT_W'(IDX_W);
                     state_in          = (n == '0) ? S_PUSH : S_MOD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MOD: begin
            rem_in     = rem_step;
            shift_in   = {shift_ff[IDX_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(1)) begin
               state_in = S_WRAP;
            end
         end
         S_WRAP: begin
            entry_in.index = ADDR_W'(start_sum);
            state_in       = S_PUSH;
         end
         S_PUSH: begin
            if (!queue_full) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      entry_ff   <= entry_in;
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      bit_cnt_ff <= bit_cnt_in;
      back_ff    <= back_in;
   end

   assign push_valid = (state_ff == S_PUSH);
   assign push_entry = entry_ff;

endmodule

// ----- src/npws_queue.sv -----
// ----------------------------------------------------------------------------
// npws_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module npws_queue
   import npws_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  npws_entry_type push_entry,
   output logic           full,
   output logic           not_empty,
   input  logic           pop,
   output npws_entry_type head
);

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   npws_entry_type       slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0]   level_ff,  level_in;
   logic                 push;

   assign full      = (level_ff == LEVEL_W'(QUEUE_DEPTH));
   assign not_empty = (level_ff != '0);
   assign push      = push_valid && !full;
   assign head      = slots_ff[rd_ptr_ff];

   // pointer wrap and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- src/npws_back.sv -----
// ----------------------------------------------------------------------------
// npws_back
// Executes queued items: table writes and pipelined nearest point scans.
// ----------------------------------------------------------------------------
module npws_back
   import npws_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [COUNT_W-1:0] point_count,
   input  logic             queue_not_empty,
   input  npws_entry_type   queue_head,
   output logic             queue_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [IDX_W-1:0] rsp_nearest_index,
   output logic             rsp_found
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FIN
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     j_ff,     j_in;
   logic [CNT_W-1:0]      rem_ff,   rem_in;
   logic [COORD_BITS-1:0] qx_ff, qy_ff, qz_ff;

   // scan pipeline: read, difference, square, partial sum, sum
   logic                  v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic [ADDR_W-1:0]     idx0_ff, idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff, dz_ff;
   logic [SQ_W-1:0]       sqx_ff, sqy_ff, sqz_ff, sqz_d_ff;
   logic [DIST_W-1:0]     sum_xy_ff, dist_ff;

   // running best
   logic                  best_found_ff, best_found_in;
   logic [DIST_W-1:0]     best_dist_ff,  best_dist_in;
   logic [ADDR_W-1:0]     best_idx_ff,   best_idx_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic                  rsp_found_ff, rsp_found_in;

   logic [CNT_W-1:0]      n;
   logic                  ram_we;
   logic                  ram_re;
   logic [3*COORD_BITS-1:0] ram_rdata;
   logic [COORD_BITS-1:0] px, py, pz;
   logic                  pipe_busy;
   logic                  out_free;

   // absolute difference of two two's complement coordinates
   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      logic [COORD_BITS:0] d;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      if (d[COORD_BITS]) begin
         d = -d;
      end
      return d[COORD_BITS-1:0];
   endfunction

   assign n         = npws_eff_count(point_count);
   assign queue_pop = (state_ff == S_IDLE) && queue_not_empty;
   assign ram_we    = queue_pop && queue_head.is_write;
   assign ram_re    = (state_ff == S_SCAN);
   assign pipe_busy = v0_ff || v1_ff || v2_ff || v3_ff || v4_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   npws_ram #(
      .WIDTH (3 * COORD_BITS),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (queue_head.index),
      .wr_data ({queue_head.x, queue_head.y, queue_head.z}),
      .rd_en   (ram_re),
      .rd_addr (j_ff),
      .rd_data (ram_rdata)
   );

   assign px = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
   assign py = ram_rdata[2*COORD_BITS-1:COORD_BITS];
   assign pz = ram_rdata[COORD_BITS-1:0];

   // scan sequencer and result hand-off
   always_comb begin
      state_in      = state_ff;
      j_in          = j_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_found_in  = rsp_found_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (queue_pop && !queue_head.is_write) begin
               j_in     = queue_head.index;
               rem_in   = queue_head.count;
               state_in = (queue_head.count == '0) ? S_FIN : S_SCAN;
            end
         end
         S_SCAN: begin
            rem_in = rem_ff - 1'b1;
            if ((CNT_W'(j_ff) + 1'b1) >= n) begin
               j_in = '0;
            end else begin
               j_in = j_ff + 1'b1;
            end
            if (rem_ff == CNT_W'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!pipe_busy) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = best_found_ff;
               rsp_index_in = best_found_ff ? IDX_W'(best_idx_ff) : '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // best so far: strictly smaller wins, so the first scanned keeps a tie
   always_comb begin
      best_found_in = best_found_ff;
      best_dist_in  = best_dist_ff;
      best_idx_in   = best_idx_ff;
      if (queue_pop) begin
         best_found_in = 1'b0;
      end else if (v4_ff && (!best_found_ff || dist_ff < best_dist_ff)) begin
         best_found_in = 1'b1;
         best_dist_in  = dist_ff;
         best_idx_in   = idx4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         v0_ff         <= ram_re;
         v1_ff         <= v0_ff;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         v4_ff         <= v3_ff;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      j_ff         <= j_in;
      rem_ff       <= rem_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_found_ff <= rsp_found_in;
      // query capture
      if (queue_pop) begin
         qx_ff <= queue_head.x;
         qy_ff <= queue_head.y;
         qz_ff <= queue_head.z;
      end
      // distance pipeline
      idx0_ff   <= j_ff;
      idx1_ff   <= idx0_ff;
      dx_ff     <= abs_diff(px, qx_ff);
      dy_ff     <= abs_diff(py, qy_ff);
      dz_ff     <= abs_diff(pz, qz_ff);
      idx2_ff   <= idx1_ff;
      sqx_ff    <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sqy_ff    <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
      sqz_ff    <= SQ_W'(dz_ff) * SQ_W'(dz_ff);
      idx3_ff   <= idx2_ff;
      sum_xy_ff <= DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
      sqz_d_ff  <= sqz_ff;
      idx4_ff   <= idx3_ff;
      dist_ff   <= sum_xy_ff + DIST_W'(sqz_d_ff);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_index_ff;
   assign rsp_found         = rsp_found_ff;

   // an empty scan reports index zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_index_ff == '0))
      else $error("empty scan result with nonzero index");

   // the read address stays inside the entries in use
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> ((CNT_W'(j_ff) < n) && (rem_ff != '0)))
      else $error("scan address or remaining count out of range");

   // no distance still in flight when the result is taken
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> !pipe_busy)
      else $error("result formed with scan pipeline busy");

   // a new item is taken only after the previous scan was handed off
   assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !pipe_busy)
      else $error("queue popped while scan pipeline busy");

endmodule

// ----- src/nearest_point_window_search.sv -----
// Flow: with the back idle a write reaches the table as the back pops it from the queue;
// a search reads its entries in turn, drains the pipeline and then registers the result; a
// windowed search first has the front reduce the centre index modulo n and wrap the start.
// Throughput: the front takes a new item only after it has pushed the last into the queue;
// a scan reads one table entry per cycle through the single read port.
// Reset: clears control state and sets the point count to 1; the point table stays unwritten.
// ----------------------------------------------------------------------------
// nearest_point_window_search
// Point table with full and windowed nearest point search by squared distance.
// ----------------------------------------------------------------------------
module nearest_point_window_search
   import npws_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [COUNT_W-1:0]      csr_write_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CMD_W-1:0]        req_command,
   input  logic [IDX_W-1:0]        req_entry_index,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic [IDX_W-1:0]        req_last_index,
   input  logic [COUNT_W-1:0]      req_window_size,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [IDX_W-1:0]        rsp_nearest_index,
   output logic                    rsp_found
);

   logic [COUNT_W-1:0] point_count_ff;
   logic               push_valid;
   logic               queue_full;
   logic               queue_not_empty;
   logic               queue_pop;
   npws_entry_type     push_entry;
   npws_entry_type     queue_head;

   // point count register
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= COUNT_W'(1);
      end else if (csr_write_enable) begin
         point_count_ff <= csr_write_data;
      end
   end

   npws_front u_front (
      .clock           (clock),
      .reset           (reset),
      .point_count     (point_count_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_entry_index (req_entry_index),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_last_index  (req_last_index),
      .req_window_size (req_window_size),
      .push_valid      (push_valid),
      .queue_full      (queue_full),
      .push_entry      (push_entry)
   );

   npws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .pop        (queue_pop),
      .head       (queue_head)
   );

   npws_back u_back (
      .clock             (clock),
      .reset             (reset),
      .point_count       (point_count_ff),
      .queue_not_empty   (queue_not_empty),
      .queue_head        (queue_head),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_found         (rsp_found)
   );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest point window search. A scoreboard
// mirrors the point table and point count, predicts the nearest index of every
// accepted search and checks each returned item in order, under random idling
// on both channels, a long receiver hold-off and several point count settings.
// ----------------------------------------------------------------------------
module tb;
   import npws_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam int WRITE_DRAIN    = 16;
   localparam int TAIL_CYCLES    = 64;
   localparam int FILL_POINTS    = 32;
   localparam logic signed [POS_W-1:0] POS_HI = 24'h7FFFFF;
   localparam logic signed [POS_W-1:0] POS_LO = 24'h800000;

   // one request item
   typedef struct {
      npws_cmd_code_type       cmd;
      logic [IDX_W-1:0]        entry;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [IDX_W-1:0]        last_idx;
      logic [COUNT_W-1:0]      win;
   } point_req_type;

   // one search result
   typedef struct packed {
      logic [IDX_W-1:0] nearest;
      logic             found;
   } nearest_hit_type;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]      csr_write_data   = '0;
   logic                    req_valid        = 1'b0;
   logic                    req_ready;
   logic [CMD_W-1:0]        req_command      = '0;
   logic [IDX_W-1:0]        req_entry_index  = '0;
   logic signed [POS_W-1:0] req_pos_x        = '0;
   logic signed [POS_W-1:0] req_pos_y        = '0;
   logic signed [POS_W-1:0] req_pos_z        = '0;
   logic [IDX_W-1:0]        req_last_index   = '0;
   logic [COUNT_W-1:0]      req_window_size  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready        = 1'b0;
   logic [IDX_W-1:0]        rsp_nearest_index;
   logic                    rsp_found;

   // scoreboard state: mirrored table and point count
   logic signed [POS_W-1:0] pts_x [MAX_POINTS];
   logic signed [POS_W-1:0] pts_y [MAX_POINTS];
   logic signed [POS_W-1:0] pts_z [MAX_POINTS];
   logic [COUNT_W-1:0]      count_cfg = 13'd1;

   point_req_type   pending[$];
   point_req_type   on_wire;
   nearest_hit_type awaited_hits[$];

   int errors         = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   int hold_left      = 0;
   int holds_asked    = 0;
   int holds_served   = 0;
   int idle_cycles    = 0;

   nearest_point_window_search i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_entry_index   (req_entry_index),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_last_index    (req_last_index),
      .req_window_size   (req_window_size),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_found         (rsp_found)
   );

   always #1 clock = ~clock;

   // squared distance from a stored point to the query
   function automatic longint unsigned dist_sq(input int e, input point_req_type r);
      longint dx;
      longint dy;
      longint dz;
      dx = longint'(pts_x[e]) - longint'(r.x);
      dy = longint'(pts_y[e]) - longint'(r.y);
      dz = longint'(pts_z[e]) - longint'(r.z);
      return longint'(dx * dx + dy * dy + dz * dz);
   endfunction

   // update the mirrored table, or scan it and queue the awaited result
   task automatic apply_item(input point_req_type r);
      int n;
      int w;
      int back;
      int cnt;
      int j;
      longint unsigned best;
      longint unsigned d;
      nearest_hit_type hit;
      n = (count_cfg > MAX_POINTS) ? MAX_POINTS : int'(count_cfg);
      hit = '0;
      best = 0;
      case (r.cmd)
         CMD_WRITE: begin
            pts_x[r.entry] = r.x;
            pts_y[r.entry] = r.y;
            pts_z[r.entry] = r.z;
         end
         CMD_FULL, CMD_WINDOW: begin
            cnt = 0;
            j = 0;
            if (n != 0 && r.cmd == CMD_FULL) begin
               cnt = n;
            end else if (n != 0) begin
               w = (int'(r.win) > n) ? n : int'(r.win);
               back = w / 4;
               cnt = back + (w * 3) / 4;
               j = ((int'(r.last_idx) % n) + n - back) % n;
            end
            // first scanned entry wins a tie
            for (int k = 0; k < cnt; k++) begin
               d = dist_sq(j, r);
               if (!hit.found || d < best) begin
                  hit.found = 1'b1;
                  hit.nearest = IDX_W'(j);
                  best = d;
               end
               j = (j + 1 == n) ? 0 : j + 1;
            end
            awaited_hits.push_back(hit);
         end
         default: begin
         end
      endcase
   endtask

   // driver: presents items from the pending queue, random gaps after items
   always @(posedge clock) begin
      point_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) apply_item(on_wire);
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending.size() != 0) begin
               nxt = pending.pop_front();
               on_wire = nxt;
               req_valid       <= 1'b1;
               req_command     <= nxt.cmd;
               req_entry_index <= nxt.entry;
               req_pos_x       <= nxt.x;
               req_pos_y       <= nxt.y;
               req_pos_z       <= nxt.z;
               req_last_index  <= nxt.last_idx;
               req_window_size <= nxt.win;
               if ($urandom_range(0, 99) < send_idle_pct) send_gap <= $urandom_range(1, 17);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks results in order and drives the receiver stalls
   always @(posedge clock) begin
      nearest_hit_type want;
      if (reset) begin
         rsp_ready    <= 1'b0;
         hold_left    <= 0;
         stall_left   <= 0;
         holds_served <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_hits.size() == 0) begin
               $error("unexpected result: nearest_index %0d found %0b",
                      rsp_nearest_index, rsp_found);
               errors++;
            end else begin
               want = awaited_hits.pop_front();
               if (rsp_nearest_index !== want.nearest) begin
                  $error("nearest_index: expected %0d, actual %0d",
                         want.nearest, rsp_nearest_index);
                  errors++;
               end
               if (rsp_found !== want.found) begin
                  $error("found: expected %0b, actual %0b", want.found, rsp_found);
                  errors++;
               end
            end
         end
         // long hold-off first, then short random stalls
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (holds_served != holds_asked) begin
            rsp_ready    <= 1'b0;
            hold_left    <= HOLD_CYCLES - 1;
            holds_served <= holds_served + 1;
         end else if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 99) < recv_stall_pct) begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 16);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("** nearest_point_window_search: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_item(input npws_cmd_code_type c, input int e,
                             input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y,
                             input logic signed [POS_W-1:0] z,
                             input int last_idx, input int win);
      point_req_type r;
      r.cmd      = c;
      r.entry    = IDX_W'(e);
      r.x        = x;
      r.y        = y;
      r.z        = z;
      r.last_idx = IDX_W'(last_idx);
      r.win      = COUNT_W'(win);
      pending.push_back(r);
   endtask

   // wait until every item is taken and answered, then let writes drain
   task automatic settle();
      do @(negedge clock);
      while (pending.size() != 0 || req_valid || awaited_hits.size() != 0);
      repeat (WRITE_DRAIN) @(negedge clock);
   endtask

   task automatic set_point_count(input logic [COUNT_W-1:0] v);
      settle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      count_cfg = v;
      @(negedge clock);
   endtask

   // random item with most writes inside the active range
   task automatic queue_random_item(input int n);
      int span;
      int pick;
      int e;
      int src;
      int last_idx;
      int win;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      span = (n < 1) ? 1 : ((n > MAX_POINTS) ? MAX_POINTS : n);
      e = $urandom_range(0, MAX_POINTS - 1);
      last_idx = $urandom_range(0, MAX_POINTS - 1);
      win = $urandom_range(0, 8191);
      src = $urandom_range(0, span - 1);
      case ($urandom_range(0, 9))
         0, 1: begin
            x = $urandom_range(0, 1) ? POS_HI : POS_LO;
            y = $urandom_range(0, 1) ? POS_HI : POS_LO;
            z = $urandom_range(0, 1) ? POS_HI : POS_LO;
         end
         2, 3, 4: begin
            // close to a stored point, sometimes right on it
            x = pts_x[src] + POS_W'($urandom_range(0, 32)) - POS_W'(16);
            y = pts_y[src] + POS_W'($urandom_range(0, 32)) - POS_W'(16);
            z = pts_z[src] + POS_W'($urandom_range(0, 32)) - POS_W'(16);
            if ($urandom_range(0, 3) == 0) begin
               x = pts_x[src];
               y = pts_y[src];
               z = pts_z[src];
            end
         end
         default: begin
            x = POS_W'($urandom());
            y = POS_W'($urandom());
            z = POS_W'($urandom());
         end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         if ($urandom_range(0, 9) < 6) e = $urandom_range(0, span - 1);
         queue_item(CMD_WRITE, e, x, y, z, last_idx, win);
      end else if (pick < 29) begin
         queue_item(CMD_NONE, e, x, y, z, last_idx, win);
      end else if (pick < 60) begin
         queue_item(CMD_FULL, e, x, y, z, last_idx, win);
      end else begin
         case ($urandom_range(0, 5))
            0: win = $urandom_range(0, 3);
            1, 2: begin
            end
            default: win = $urandom_range(0, span + 2);
         endcase
         if ($urandom_range(0, 1) == 0) last_idx = $urandom_range(0, span - 1);
         queue_item(CMD_WINDOW, e, x, y, z, last_idx, win);
      end
   endtask

   task automatic random_phase(input int n_items, input logic [COUNT_W-1:0] n,
                               input int send_pct, input int stall_pct);
      set_point_count(n);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      repeat (n_items) queue_random_item(int'(n));
   endtask

   initial begin
      int idle_pick[4];
      int stall_pick[4];
      idle_pick  = '{0, 10, 30, 60};
      stall_pick = '{0, 2, 5, 12};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill every entry a scan can reach: the low entries and the top two for wrapped windows
      send_idle_pct  = 3;
      recv_stall_pct = 5;
      for (int e = 0; e < FILL_POINTS; e++) begin
         queue_item(CMD_WRITE, e, POS_W'($urandom()), POS_W'($urandom()),
                    POS_W'($urandom()), 0, 0);
      end
      for (int e = MAX_POINTS - 2; e < MAX_POINTS; e++) begin
         queue_item(CMD_WRITE, e, POS_W'($urandom()), POS_W'($urandom()),
                    POS_W'($urandom()), 0, 0);
      end
      // point count still at its reset value of one
      queue_item(CMD_FULL, 0, 24'sd5, -24'sd7, 24'sd9, 0, 0);
      queue_item(CMD_WINDOW, 0, 24'sd5, -24'sd7, 24'sd9, 3, 5);

      // small table with extremes and a duplicated point
      random_phase(0, 13'd8, 20, 5);
      queue_item(CMD_WRITE, 0, POS_HI, POS_HI, POS_HI, 0, 0);
      queue_item(CMD_WRITE, 1, POS_LO, POS_LO, POS_LO, 0, 0);
      queue_item(CMD_WRITE, 2, 24'sd100, -24'sd200, 24'sd300, 0, 0);
      queue_item(CMD_WRITE, 3, 24'sd0, 24'sd0, 24'sd0, 0, 0);
      queue_item(CMD_WRITE, 4, -24'sd64, 24'sd64, 24'sd0, 0, 0);
      queue_item(CMD_WRITE, 5, 24'sd100, -24'sd200, 24'sd300, 0, 0);
      queue_item(CMD_WRITE, 6, POS_HI, POS_LO, 24'sd0, 0, 0);
      queue_item(CMD_WRITE, 7, 24'sd1, 24'sd1, 24'sd1, 0, 0);
      // tie: lower entry scanned first, then a wrapped window scanning 5 first
      queue_item(CMD_FULL, 0, 24'sd100, -24'sd200, 24'sd300, 0, 0);
      queue_item(CMD_WINDOW, 0, 24'sd100, -24'sd200, 24'sd300, 6, 8);
      queue_item(CMD_FULL, 0, POS_HI, POS_HI, POS_HI, 0, 0);
      queue_item(CMD_FULL, 0, POS_LO, POS_LO, POS_LO, 0, 0);
      // empty windows, clamped window with out-of-range centre, tiny windows
      queue_item(CMD_WINDOW, 0, 24'sd1, 24'sd1, 24'sd1, 3, 0);
      queue_item(CMD_WINDOW, 0, 24'sd1, 24'sd1, 24'sd1, 3, 1);
      queue_item(CMD_WINDOW, 0, 24'sd1, 24'sd1, 24'sd1, 4095, 8191);
      queue_item(CMD_WINDOW, 0, POS_LO, POS_LO, POS_LO, 0, 2);
      queue_item(CMD_WINDOW, 0, POS_HI, POS_LO, 24'sd0, 0, 4);
      queue_item(CMD_NONE, 4095, POS_HI, POS_LO, POS_HI, 4095, 8191);

      // no entries in use: every search is empty
      set_point_count(13'd0);
      queue_item(CMD_FULL, 0, 24'sd3, 24'sd3, 24'sd3, 0, 0);
      queue_item(CMD_WINDOW, 0, 24'sd3, 24'sd3, 24'sd3, 2, 16);

      // count beyond the table saturates, then the table size itself:
      // windows near the bottom wrap through the top two entries
      set_point_count(13'h1FFF);
      queue_item(CMD_WINDOW, 0, 24'sd0, 24'sd0, 24'sd0, 2, 16);
      queue_item(CMD_WINDOW, 0, POS_HI, 24'sd0, POS_LO, 0, 8);
      set_point_count(13'd4096);
      queue_item(CMD_WINDOW, 0, POS_LO, POS_HI, 24'sd0, 1, 12);
      queue_item(CMD_WINDOW, 0, 24'sd0, 24'sd0, 24'sd0, 3, 20);

      // random phases over several point counts
      random_phase(16, COUNT_W'($urandom_range(2, FILL_POINTS)),
                   idle_pick[$urandom_range(0, 3)], stall_pick[$urandom_range(0, 3)]);
      random_phase(8, 13'd1, idle_pick[$urandom_range(0, 3)], stall_pick[$urandom_range(0, 3)]);
      random_phase(16, COUNT_W'($urandom_range(9, FILL_POINTS)),
                   idle_pick[$urandom_range(0, 3)], stall_pick[$urandom_range(0, 3)]);

      // receiver held off while the sender keeps offering items
      set_point_count(13'd6);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      holds_asked++;
      repeat (24) queue_random_item(6);

      // closing phase without idling
      random_phase(16, COUNT_W'($urandom_range(2, FILL_POINTS)), 0, 0);

      settle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (errors == 0 && awaited_hits.size() == 0) begin
         $display("** nearest_point_window_search: PASSED **");
      end else begin
         $display("** nearest_point_window_search: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/npws_pkg.sv
src/npws_ram.sv
src/npws_front.sv
src/npws_queue.sv
src/npws_back.sv
src/nearest_point_window_search.sv
tb/sv/tb.sv
